// ===== rtl/core/kfr_pkg.sv =====
// ----------------------------------------------------------------------------
// kfr_pkg: shared types and constants for the key frame reassembly core
// Command and status codes, field widths, default sizing, and the
// control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package kfr_pkg;

  // default sizing
  localparam int SLOTS_DEF           = 4;
  localparam int MAX_FRAME_BYTES_DEF = 16384;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int FNO_W    = 32;
  localparam int UID_W    = 32;
  localparam int SIZE_W   = 15;
  localparam int BYTE_W   = 8;
  localparam int SEL_W    = 2;
  localparam int OFS_W    = 14;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DISCARD    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ       = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture the input word
    logic select;    // pick a slot for a new fragment
    logic append;    // append the held byte to the current slot
    logic rd_issue;  // start a store read
    logic rd_done;   // load the read result
    logic free;      // clear the addressed slot
  } kfr_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_fragment;  // a fragment is open
    logic last;         // held byte ends its fragment
    logic out_busy;     // result register full and not taken this cycle
  } kfr_stat_t;

endpackage

// ===== rtl/core/key_frame_fragment_reassembly_core.sv =====
// ----------------------------------------------------------------------------
// key_frame_fragment_reassembly_core: key frame fragment reassembly table
// Gathers key frame fragments, one payload byte per word, into SLOTS slots,
// reports fragment completion, and serves byte reads and slot frees.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | cmd, frame_number, user_id, total_size,
//          |                      | data_byte, last_in_fragment, slot_select,
//          |                      | byte_offset
//  out     | out_valid / out_ready| status, slot_index, frame_size, read_byte
//
//  Steps per word: an append inside an open fragment runs the append step,
//  the first byte of a fragment runs slot select (over the header compare)
//  and then append, a read runs the registered store read and then the result
//  load, a free runs the free step and an unused code none; one word is worked at a
//  time. Reset (rst, synchronous) clears all slot headers and counts and
//  closes any open fragment; the byte store is not cleared. A result left in
//  the output register does not block intake: only a step that must load a
//  new result waits for out_ready.
//
module key_frame_fragment_reassembly_core
  import kfr_pkg::*;
#(
  parameter int SLOTS           = SLOTS_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [FNO_W-1:0]    frame_number,
  input  logic [UID_W-1:0]    user_id,
  input  logic [SIZE_W-1:0]   total_size,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                last_in_fragment,
  input  logic [SEL_W-1:0]    slot_select,
  input  logic [OFS_W-1:0]    byte_offset,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SEL_W-1:0]    slot_index,
  output logic [SIZE_W-1:0]   frame_size,
  output logic [BYTE_W-1:0]   read_byte
);

  kfr_ctrl_t ctl;
  kfr_stat_t stat;

  // sequencer: decides which datapath step runs each cycle
  kfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat),
    .ctl      (ctl)
  );

  // slot table, byte store and result register
  kfr_dp #(
    .SLOTS           (SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .frame_number     (frame_number),
    .user_id          (user_id),
    .total_size       (total_size),
    .data_byte        (data_byte),
    .last_in_fragment (last_in_fragment),
    .slot_select      (slot_select),
    .byte_offset      (byte_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .slot_index       (slot_index),
    .frame_size       (frame_size),
    .read_byte        (read_byte)
  );

endmodule

// ===== rtl/core/kfr_ram.sv =====
// ----------------------------------------------------------------------------
// kfr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds until the
// next read enable.
// ----------------------------------------------------------------------------
module kfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/kfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// kfr_ctrl: command sequencer
// Accepts one word at a time and steps the datapath through slot select,
// append, store read or free.
// ----------------------------------------------------------------------------
module kfr_ctrl
  import kfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd,
  input  kfr_stat_t        stat,
  output kfr_ctrl_t        ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SELECT,
    S_APPEND,
    S_READ,
    S_READ_OUT,
    S_FREE
  } state_t;

  state_t state;
  logic   idle;
  logic   accept;

  assign in_ready = idle;
  assign accept   = in_valid && idle;

  always_comb begin
    ctl          = '0;
    ctl.latch    = accept;
    ctl.select   = (state == S_SELECT);
    ctl.append   = (state == S_APPEND) && !(stat.last && stat.out_busy);
    ctl.rd_issue = (state == S_READ);
    ctl.rd_done  = (state == S_READ_OUT) && !stat.out_busy;
    ctl.free     = (state == S_FREE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idle  <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_APPEND: begin
                state <= stat.in_fragment ? S_APPEND : S_SELECT;
                idle  <= 1'b0;
              end
              CMD_READ: begin
                state <= S_READ;
                idle  <= 1'b0;
              end
              CMD_FREE: begin
                state <= S_FREE;
                idle  <= 1'b0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SELECT: state <= S_APPEND;
        S_APPEND: begin
          if (ctl.append) begin
            state <= S_IDLE;
            idle  <= 1'b1;
          end
        end
        S_READ: state <= S_READ_OUT;
        S_READ_OUT: begin
          if (ctl.rd_done) begin
            state <= S_IDLE;
            idle  <= 1'b1;
          end
        end
        S_FREE: begin
          state <= S_IDLE;
          idle  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          idle  <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/kfr_dp.sv =====
// ----------------------------------------------------------------------------
// kfr_dp: slot table, byte store and result register
// Holds per-slot headers and counts, matches headers in parallel, writes
// bytes to the store and builds result words.
// ----------------------------------------------------------------------------
module kfr_dp
  import kfr_pkg::*;
#(
  parameter int SLOTS           = SLOTS_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  kfr_ctrl_t           ctl,
  output kfr_stat_t           stat,
  input  logic [FNO_W-1:0]    frame_number,
  input  logic [UID_W-1:0]    user_id,
  input  logic [SIZE_W-1:0]   total_size,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                last_in_fragment,
  input  logic [SEL_W-1:0]    slot_select,
  input  logic [OFS_W-1:0]    byte_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SEL_W-1:0]    slot_index,
  output logic [SIZE_W-1:0]   frame_size,
  output logic [BYTE_W-1:0]   read_byte
);

  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OFF_W     = $clog2(MAX_FRAME_BYTES);
  localparam int CNT_W     = $clog2(MAX_FRAME_BYTES + 2);
  localparam int CMP_W     = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int RAM_DEPTH = SLOTS * (2 ** OFF_W);
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // held input word
  logic [FNO_W-1:0]  fno_q;
  logic [UID_W-1:0]  uid_q;
  logic [SIZE_W-1:0] total_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic [SEL_W-1:0]  sel_q;
  logic [OFS_W-1:0]  off_q;

  // slot table
  logic [FNO_W-1:0]  slot_fno   [SLOTS];
  logic [UID_W-1:0]  slot_uid   [SLOTS];
  logic [SIZE_W-1:0] slot_total [SLOTS];
  logic [CNT_W-1:0]  slot_count [SLOTS];
  logic              in_fragment;
  logic [SLOT_W-1:0] cur_slot;

  // slot choice
  logic              match_found;
  logic [SLOT_W-1:0] match_idx;
  logic              empty_found;
  logic [SLOT_W-1:0] empty_idx;
  logic [SLOT_W-1:0] pick_idx;

  // append path
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  cnt_new;
  logic              cnt_room;
  logic [CMP_W-1:0]  cnt_cmp;
  logic [CMP_W-1:0]  total_cmp;
  logic              is_complete;
  logic              is_short;

  // read path
  logic              sel_ok;
  logic [SLOT_W-1:0] sel_idx;
  logic [CNT_W-1:0]  sel_cnt;
  logic              rd_hit;
  logic              rd_hit_q;
  logic [SIZE_W-1:0] rd_size_q;

  // store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      fno_q   <= frame_number;
      uid_q   <= user_id;
      total_q <= total_size;
      byte_q  <= data_byte;
      last_q  <= last_in_fragment;
      sel_q   <= slot_select;
      off_q   <= byte_offset;
    end
  end

  // lowest matching header, else lowest empty slot, else slot 0
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (slot_fno[s] == fno_q && slot_uid[s] == uid_q) begin
        match_found = 1'b1;
        match_idx   = SLOT_W'(s);
      end
      if (slot_count[s] == '0) begin
        empty_found = 1'b1;
        empty_idx   = SLOT_W'(s);
      end
    end
    if (match_found) begin
      pick_idx = match_idx;
    end else if (empty_found) begin
      pick_idx = empty_idx;
    end else begin
      pick_idx = '0;
    end
  end

  always_comb begin
    cur_cnt     = slot_count[cur_slot];
    cnt_room    = CMP_W'(cur_cnt) < CMP_W'(MAX_FRAME_BYTES);
    cnt_new     = cnt_room ? (cur_cnt + CNT_W'(1)) : CNT_W'(MAX_FRAME_BYTES + 1);
    cnt_cmp     = CMP_W'(cnt_new);
    total_cmp   = CMP_W'(slot_total[cur_slot]);
    is_complete = (cnt_cmp == total_cmp);
    is_short    = (cnt_cmp < total_cmp);
  end

  always_comb begin
    sel_ok  = (int'(sel_q) < SLOTS);
    sel_idx = sel_ok ? SLOT_W'(sel_q) : '0;
    sel_cnt = slot_count[sel_idx];
    rd_hit  = sel_ok && (CMP_W'(off_q) < CMP_W'(sel_cnt)) &&
              (CMP_W'(off_q) < CMP_W'(MAX_FRAME_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_fno[s]   <= '0;
        slot_uid[s]   <= '0;
        slot_total[s] <= '0;
        slot_count[s] <= '0;
      end
      in_fragment <= 1'b0;
      cur_slot    <= '0;
    end else begin
      if (ctl.select) begin
        if (!match_found && !empty_found) begin
          slot_count[0] <= '0;
        end
        slot_fno[pick_idx]   <= fno_q;
        slot_uid[pick_idx]   <= uid_q;
        slot_total[pick_idx] <= total_q;
        cur_slot             <= pick_idx;
        in_fragment          <= 1'b1;
      end
      if (ctl.append) begin
        if (last_q && !is_complete && !is_short) begin
          // overflow drops the slot
          slot_fno[cur_slot]   <= '0;
          slot_uid[cur_slot]   <= '0;
          slot_total[cur_slot] <= '0;
          slot_count[cur_slot] <= '0;
        end else begin
          slot_count[cur_slot] <= cnt_new;
        end
        if (last_q) begin
          in_fragment <= 1'b0;
        end
      end
      if (ctl.free && sel_ok) begin
        slot_fno[sel_idx]   <= '0;
        slot_uid[sel_idx]   <= '0;
        slot_total[sel_idx] <= '0;
        slot_count[sel_idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      rd_hit_q  <= rd_hit;
      rd_size_q <= sel_ok ? SIZE_W'(sel_cnt) : '0;
    end
  end

  assign ram_we    = ctl.append && cnt_room;
  assign ram_waddr = ADDR_W'({cur_slot, OFF_W'(cur_cnt)});
  assign ram_raddr = ADDR_W'({sel_idx, OFF_W'(off_q)});

  kfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (byte_q),
    .re    (ctl.rd_issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctl.append && last_q) || ctl.rd_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append && last_q) begin
      if (is_complete) begin
        status <= ST_COMPLETE;
      end else if (is_short) begin
        status <= ST_INCOMPLETE;
      end else begin
        status <= ST_DISCARD;
      end
      slot_index <= SEL_W'(cur_slot);
      frame_size <= SIZE_W'(cnt_new);
      read_byte  <= '0;
    end else if (ctl.rd_done) begin
      status     <= ST_READ;
      slot_index <= sel_q;
      frame_size <= rd_size_q;
      read_byte  <= rd_hit_q ? ram_rdata : '0;
    end
  end

  assign stat.in_fragment = in_fragment;
  assign stat.last        = last_q;
  assign stat.out_busy    = out_valid && !out_ready;

endmodule

// ===== test/key_frame_fragment_reassembly_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_frame_fragment_reassembly_core_tb: self-checking bench for the core
// Feeds append, read, free and unused words through the input channel and
// checks every result word against a cycle-free model of the slot table.
// The run covers directed corners and random fragment traffic, with random
// idling and backpressure on both channels.
// ----------------------------------------------------------------------------
module key_frame_fragment_reassembly_core_tb;
  import kfr_pkg::*;

  localparam int N_SLOTS       = SLOTS_DEF;
  localparam int FRAME_CAP     = MAX_FRAME_BYTES_DEF;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 33;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int POOL          = 6;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [FNO_W-1:0]  fno;
    logic [UID_W-1:0]  uid;
    logic [SIZE_W-1:0] total;
    logic [BYTE_W-1:0] dbyte;
    logic              last;
    logic [SEL_W-1:0]  sel;
    logic [OFS_W-1:0]  ofs;
  } frame_word_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SEL_W-1:0]    slot;
    logic [SIZE_W-1:0]   size;
    logic [BYTE_W-1:0]   data;
  } result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = CMD_APPEND;
  logic [FNO_W-1:0]    frame_number = '0;
  logic [UID_W-1:0]    user_id = '0;
  logic [SIZE_W-1:0]   total_size = '0;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                last_in_fragment = 1'b0;
  logic [SEL_W-1:0]    slot_select = '0;
  logic [OFS_W-1:0]    byte_offset = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SEL_W-1:0]    slot_index;
  logic [SIZE_W-1:0]   frame_size;
  logic [BYTE_W-1:0]   read_byte;

  key_frame_fragment_reassembly_core uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .frame_number     (frame_number),
    .user_id          (user_id),
    .total_size       (total_size),
    .data_byte        (data_byte),
    .last_in_fragment (last_in_fragment),
    .slot_select      (slot_select),
    .byte_offset      (byte_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .slot_index       (slot_index),
    .frame_size       (frame_size),
    .read_byte        (read_byte)
  );

  always #4 clk = ~clk;

  // stimulus and scoreboard
  frame_word_t pending_words[$];
  result_t     expected_results[$];
  frame_word_t offered;
  int          real_words = 0;
  int          errors = 0;
  int          cycles = 0;
  logic        steady = 1'b0;     // no idling on either side
  logic        hold_start = 1'b0; // one long receiver stall
  bit          hold_done = 0;
  int          hold_left = 0;

  logic [FNO_W-1:0] pool_fno[POOL];
  logic [UID_W-1:0] pool_uid[POOL];

  // slot table model
  logic [FNO_W-1:0]  slot_fno[N_SLOTS];
  logic [UID_W-1:0]  slot_uid[N_SLOTS];
  int                slot_total[N_SLOTS];
  int                slot_cnt[N_SLOTS];
  logic [BYTE_W-1:0] store_mem[N_SLOTS*FRAME_CAP];
  bit                frag_open = 0;
  int                cur_slot = 0;

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_fno[i] = '0;
      slot_uid[i] = '0;
      slot_total[i] = 0;
      slot_cnt[i] = 0;
    end
  end

  task automatic clear_slot(input int s);
    slot_fno[s] = '0;
    slot_uid[s] = '0;
    slot_total[s] = 0;
    slot_cnt[s] = 0;
  endtask

  // Advance the slot table by one accepted word and queue its result, if any.
  task automatic apply_word(input frame_word_t w);
    int      s;
    bit      found;
    result_t r;
    case (w.cmd)
      CMD_APPEND: begin
        if (!frag_open) begin
          // header match first, then lowest empty slot, else recycle slot 0
          found = 0;
          s = 0;
          for (int i = 0; i < N_SLOTS; i++)
            if (!found && slot_fno[i] == w.fno && slot_uid[i] == w.uid) begin
              s = i;
              found = 1;
            end
          for (int i = 0; i < N_SLOTS; i++)
            if (!found && slot_cnt[i] == 0) begin
              s = i;
              found = 1;
            end
          if (!found) slot_cnt[0] = 0;
          slot_fno[s] = w.fno;
          slot_uid[s] = w.uid;
          slot_total[s] = int'(w.total);
          cur_slot = s;
          frag_open = 1;
        end
        s = cur_slot;
        if (slot_cnt[s] < FRAME_CAP) begin
          store_mem[s*FRAME_CAP + slot_cnt[s]] = w.dbyte;
          slot_cnt[s]++;
        end else begin
          slot_cnt[s] = FRAME_CAP + 1;  // saturated: byte dropped
        end
        if (w.last) begin
          frag_open = 0;
          r.slot = SEL_W'(s);
          r.size = SIZE_W'(slot_cnt[s]);
          r.data = '0;
          if (slot_cnt[s] == slot_total[s]) begin
            r.status = ST_COMPLETE;
          end else if (slot_cnt[s] < slot_total[s]) begin
            r.status = ST_INCOMPLETE;
          end else begin
            r.status = ST_DISCARD;
            clear_slot(s);
          end
          expected_results.push_back(r);
        end
      end
      CMD_READ: begin
        r.status = ST_READ;
        r.slot = w.sel;
        r.size = SIZE_W'(slot_cnt[w.sel]);
        r.data = (int'(w.ofs) < slot_cnt[w.sel]) ? store_mem[w.sel*FRAME_CAP + w.ofs] : '0;
        expected_results.push_back(r);
      end
      CMD_FREE: clear_slot(w.sel);
      default: ;
    endcase
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected result: status %0d slot %0d size %0d byte %02h",
                 status, slot_index, frame_size, read_byte);
    end else begin
      want = expected_results.pop_front();
      if (status !== want.status || slot_index !== want.slot ||
          frame_size !== want.size || read_byte !== want.data) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"mismatch: expected status %0d slot %0d size %0d byte %02h,",
                    " got %0d %0d %0d %02h"},
                   want.status, want.slot, want.size, want.data,
                   status, slot_index, frame_size, read_byte);
      end
    end
  endtask

  // Sender: offers queued words, predicting each one at its acceptance edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_word(offered);
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = pending_words.pop_front();
          cmd              <= offered.cmd;
          frame_number     <= offered.fno;
          user_id          <= offered.uid;
          total_size       <= offered.total;
          data_byte        <= offered.dbyte;
          last_in_fragment <= offered.last;
          slot_select      <= offered.sel;
          byte_offset      <= offered.ofs;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall: counted down here, once.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks result words, random backpressure plus the long stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (hold_left > 0 || (hold_start && !hold_done)) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("key_frame_fragment_reassembly_core_tb: errors");
      $finish;
    end
  end

  function automatic frame_word_t random_word(input logic [CMD_W-1:0] code);
    frame_word_t w;
    w.cmd   = code;
    w.fno   = $urandom;
    w.uid   = $urandom;
    w.total = SIZE_W'($urandom);
    w.dbyte = BYTE_W'($urandom);
    w.last  = 1'($urandom);
    w.sel   = SEL_W'($urandom);
    w.ofs   = OFS_W'($urandom);
    return w;
  endfunction

  function automatic frame_word_t read_word(input logic [SEL_W-1:0] sel,
                                            input logic [OFS_W-1:0] ofs);
    frame_word_t w;
    w = random_word(CMD_READ);
    w.sel = sel;
    w.ofs = ofs;
    return w;
  endfunction

  function automatic frame_word_t free_word(input logic [SEL_W-1:0] sel);
    frame_word_t w;
    w = random_word(CMD_FREE);
    w.sel = sel;
    return w;
  endfunction

  // mostly offsets that land in small frames, some anywhere
  function automatic logic [OFS_W-1:0] rand_offset();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick < 2) return OFS_W'($urandom_range(0, 15));
    if (pick == 2) return OFS_W'($urandom_range(0, 80));
    return OFS_W'($urandom);
  endfunction

  task automatic push_word(input frame_word_t w);
    pending_words.push_back(w);
    if (w.cmd != CMD_UNUSED) real_words++;
  endtask

  // One fragment of n bytes; only the first carries a real header.
  task automatic send_fragment(input logic [FNO_W-1:0] fno, input logic [UID_W-1:0] uid,
                               input logic [SIZE_W-1:0] total, input int n,
                               input bit sprinkle);
    frame_word_t w;
    for (int i = 0; i < n; i++) begin
      w = random_word(CMD_APPEND);
      if (i == 0) begin
        w.fno = fno;
        w.uid = uid;
        w.total = total;
      end
      w.last = (i == n - 1);
      push_word(w);
      if (sprinkle && i < n - 1 && $urandom_range(0, 19) == 0)
        push_word(read_word(SEL_W'($urandom), rand_offset()));
    end
  endtask

  // Frames split into fragments from a small header pool, with reads,
  // frees, unused codes and stray one-off fragments mixed in.
  task automatic random_traffic(input int budget);
    int target, pick, p, total, remaining, n, nfrag;
    target = real_words + budget;
    while (real_words < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        p = $urandom_range(0, POOL - 1);
        total = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 40);
        remaining = (total > 40) ? $urandom_range(1, 40) : total;
        nfrag = $urandom_range(1, 3);
        for (int f = 0; f < nfrag && remaining > 0; f++) begin
          n = (f == nfrag - 1) ? remaining : $urandom_range(1, remaining);
          remaining -= n;
          if ($urandom_range(0, 6) == 0) n += $urandom_range(1, 3);
          else if (n > 1 && $urandom_range(0, 6) == 0) n -= 1;
          send_fragment(pool_fno[p], pool_uid[p], SIZE_W'(total), n, 1'b1);
        end
      end else if (pick < 82) begin
        push_word(read_word(SEL_W'($urandom), rand_offset()));
      end else if (pick < 90) begin
        push_word(free_word(SEL_W'($urandom)));
      end else if (pick < 95) begin
        push_word(random_word(CMD_UNUSED));
      end else begin
        send_fragment($urandom, $urandom, SIZE_W'($urandom), $urandom_range(1, 3), 1'b0);
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    frame_word_t w;

    pool_fno[0] = '0;
    pool_uid[0] = '0;
    pool_fno[1] = '1;
    pool_uid[1] = '1;
    for (int i = 2; i < POOL; i++) begin
      pool_fno[i] = $urandom;
      pool_uid[i] = (i == POOL - 1) ? pool_uid[i-1] : $urandom;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // two-byte frame on the all-zero header, byte extremes
    w = random_word(CMD_APPEND);
    w.fno = '0;
    w.uid = '0;
    w.total = 15'd2;
    w.dbyte = 8'h00;
    w.last = 1'b0;
    push_word(w);
    w = random_word(CMD_APPEND);   // later byte: header fields are junk
    w.dbyte = 8'hFF;
    w.last = 1'b1;
    push_word(w);
    push_word(read_word(2'd0, '0));
    push_word(read_word(2'd0, 14'd1));
    push_word(read_word(2'd0, '1));         // beyond count
    send_fragment('1, '1, 15'd3, 2, 1'b0);  // incomplete
    send_fragment('1, '1, 15'd3, 1, 1'b0);  // completes by header match
    send_fragment(32'd7, 32'd7, 15'd0, 1, 1'b0);  // overflow discard
    send_fragment(32'd8, 32'd9, 15'd5, 1, 1'b0);
    send_fragment(32'd10, 32'd11, 15'd5, 1, 1'b0);
    send_fragment(32'd12, 32'd13, 15'd2, 2, 1'b0);  // all slots busy: recycle
    push_word(read_word(2'd0, '0));
    push_word(free_word(2'd3));
    push_word(random_word(CMD_UNUSED));
    push_word(read_word(2'd3, '0));
    // free the slot under an open fragment, which keeps appending to it
    w = random_word(CMD_APPEND);
    w.fno = 32'd14;
    w.uid = 32'd15;
    w.total = 15'd4;
    w.last = 1'b0;
    push_word(w);
    push_word(free_word(2'd3));
    w = random_word(CMD_APPEND);
    w.last = 1'b1;
    push_word(w);
    push_word(read_word(2'd3, '0));

    // sender pause until the table has answered everything
    wait_idle();

    // receiver stalls while reads keep coming: output and intake back up
    hold_start <= 1'b1;
    for (int i = 0; i < 40; i++) push_word(read_word(SEL_W'($urandom), rand_offset()));

    random_traffic(180);
    steady <= 1'b1;
    random_traffic(130);
    while (pending_words.size() != 0) @(posedge clk);
    steady <= 1'b0;
    random_traffic(250);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("key_frame_fragment_reassembly_core_tb: clean");
    else
      $display("key_frame_fragment_reassembly_core_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kfr_pkg.sv
rtl/core/kfr_ram.sv
rtl/core/kfr_ctrl.sv
rtl/core/kfr_dp.sv
rtl/core/key_frame_fragment_reassembly_core.sv
test/key_frame_fragment_reassembly_core_tb.sv
